// ----- rtl/core/cleb_pkg.sv -----
// Shared types, constants and key decoding for the cursor line edit buffer.
// Used by cleb_ctrl, cleb_datapath and cursor_line_edit_buffer.
`timescale 1ns / 1ps
`default_nettype none

package cleb_pkg;

    // Width of a node link and of a character byte.
    localparam int LINK_W = 7;
    localparam int BYTE_W = 8;

    // Default number of character nodes.
    localparam int DEFAULT_CAPACITY = 64;

    // Item kinds carried on the input tuser bit.
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_DUMP = 1'b1;

    // Keystroke codes with a meaning of their own.
    localparam logic [BYTE_W-1:0] KEY_HOME_CODE    = 8'h7B;
    localparam logic [BYTE_W-1:0] KEY_END_CODE     = 8'h7D;
    localparam logic [BYTE_W-1:0] KEY_BKSP_CODE    = 8'h23;
    localparam logic [BYTE_W-1:0] KEY_LEFT_CODE    = 8'h3C;
    localparam logic [BYTE_W-1:0] KEY_RIGHT_CODE   = 8'h3E;
    localparam logic [BYTE_W-1:0] KEY_NEWLINE_CODE = 8'h0A;

    typedef enum logic [2:0] {
        KC_HOME,
        KC_END,
        KC_BKSP,
        KC_LEFT,
        KC_RIGHT,
        KC_NOP,
        KC_CHAR
    } key_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEFT,
        ST_RIGHT,
        ST_DEL,
        ST_INS_W1,
        ST_INS_W2,
        ST_DUMP_HEAD,
        ST_DUMP_WALK
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CUR_HOME,
        OP_CUR_TAIL,
        OP_RD_PREV,
        OP_LD_PREV,
        OP_RD_NEXT,
        OP_LD_NEXT,
        OP_DEL_RD,
        OP_DEL_WR,
        OP_INS_TAKE,
        OP_INS_W1,
        OP_INS_W2,
        OP_DUMP_EMPTY,
        OP_DUMP_FIRST,
        OP_DUMP_STEP
    } dp_op_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic   accept;
        dp_op_t op;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cur_home;
        logic cur_tail;
        logic store_full;
        logic node_bad;
        logic head_empty;
        logic out_free;
        logic dump_last;
    } dp_status_t;

    function automatic key_class_t classify_key(input logic [BYTE_W-1:0] key);
        key_class_t kc;
        case (key)
            KEY_HOME_CODE:    kc = KC_HOME;
            KEY_END_CODE:     kc = KC_END;
            KEY_BKSP_CODE:    kc = KC_BKSP;
            KEY_LEFT_CODE:    kc = KC_LEFT;
            KEY_RIGHT_CODE:   kc = KC_RIGHT;
            KEY_NEWLINE_CODE: kc = KC_NOP;
            default:          kc = KC_CHAR;
        endcase
        return kc;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cleb_ctrl.sv -----
// Control state machine of the cursor line edit buffer.
// Depends on cleb_pkg; drives the datapath in cleb_datapath by command.
`timescale 1ns / 1ps
`default_nettype none

module cleb_ctrl
    import cleb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] key_byte,
    input  wire logic              kind,
    input  wire dp_status_t        status,
    output dp_cmd_t                cmd
);

    state_t     state_reg;
    state_t     state_next;
    key_class_t kclass;
    logic       accept;

    assign kclass   = classify_key(key_byte);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_DUMP)
                    begin
                        state_next = ST_DUMP_HEAD;
                    end
                    else
                    begin
                        case (kclass)
                            KC_LEFT:  state_next = status.cur_home ? ST_IDLE : ST_LEFT;
                            KC_RIGHT: state_next = status.cur_tail ? ST_IDLE : ST_RIGHT;
                            KC_BKSP:  state_next = status.cur_home ? ST_IDLE : ST_DEL;
                            KC_CHAR:  state_next = status.store_full ? ST_IDLE : ST_INS_W1;
                            default:  state_next = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_LEFT:   state_next = ST_IDLE;
            ST_RIGHT:  state_next = ST_IDLE;
            ST_DEL:    state_next = ST_IDLE;
            ST_INS_W1: state_next = status.node_bad ? ST_IDLE : ST_INS_W2;
            ST_INS_W2: state_next = ST_IDLE;
            ST_DUMP_HEAD:
            begin
                if (!status.head_empty)
                begin
                    state_next = ST_DUMP_WALK;
                end
                else if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP_WALK:
            begin
                if (status.out_free && status.dump_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd.accept = accept;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_KEY))
                begin
                    case (kclass)
                        KC_HOME:  cmd.op = OP_CUR_HOME;
                        KC_END:   cmd.op = OP_CUR_TAIL;
                        KC_LEFT:  cmd.op = status.cur_home ? OP_NONE : OP_RD_PREV;
                        KC_RIGHT: cmd.op = status.cur_tail ? OP_NONE : OP_RD_NEXT;
                        KC_BKSP:  cmd.op = status.cur_home ? OP_NONE : OP_DEL_RD;
                        KC_CHAR:  cmd.op = OP_INS_TAKE;
                        default:  cmd.op = OP_NONE;
                    endcase
                end
            end
            ST_LEFT:   cmd.op = OP_LD_PREV;
            ST_RIGHT:  cmd.op = OP_LD_NEXT;
            ST_DEL:    cmd.op = OP_DEL_WR;
            ST_INS_W1: cmd.op = OP_INS_W1;
            ST_INS_W2: cmd.op = OP_INS_W2;
            ST_DUMP_HEAD:
            begin
                if (!status.head_empty)
                begin
                    cmd.op = OP_DUMP_FIRST;
                end
                else if (status.out_free)
                begin
                    cmd.op = OP_DUMP_EMPTY;
                end
            end
            ST_DUMP_WALK:
            begin
                if (status.out_free)
                begin
                    cmd.op = OP_DUMP_STEP;
                end
            end
            default:   cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cleb_datapath.sv -----
// Datapath of the cursor line edit buffer: link memories, free-node stack,
// cursor and tail registers, and the output word register. Depends on cleb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cleb_datapath
    import cleb_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    input  wire logic [BYTE_W-1:0] key_byte,
    output dp_status_t             status,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [BYTE_W-1:0]      m_byte,
    output logic                   m_has_char,
    output logic                   m_last,
    output logic                   m_dropped
);

    localparam int NODES  = CAPACITY + 1;
    localparam int IDX_W  = $clog2(NODES);
    localparam int SIDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int K_W    = $clog2(CAPACITY + 1);
    localparam logic [LINK_W-1:0] CAP_L  = LINK_W'(CAPACITY);
    localparam logic [LINK_W-1:0] NULL_L = '0;
    localparam logic [K_W-1:0]    K_LAST = K_W'(CAPACITY - 1);

    // Storage. Node zero of next_link lives in head_reg, so reset can clear it.
    logic [BYTE_W-1:0] char_mem  [NODES];
    logic [LINK_W-1:0] next_mem  [NODES];
    logic [LINK_W-1:0] prev_mem  [NODES];
    logic [LINK_W-1:0] stack_mem [CAPACITY];

    logic [BYTE_W-1:0] char_q_reg;
    logic [LINK_W-1:0] next_q_reg;
    logic [LINK_W-1:0] prev_q_reg;
    logic [LINK_W-1:0] stack_q_reg;

    logic [LINK_W-1:0] caret_reg, caret_next;
    logic [LINK_W-1:0] tail_reg, tail_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] fresh_reg, fresh_next;
    logic [LINK_W-1:0] rc_reg, rc_next;
    logic              overflow_reg, overflow_next;
    logic [LINK_W-1:0] node_reg, node_next;
    logic [LINK_W-1:0] after_reg, after_next;
    logic              use_stack_reg, use_stack_next;
    logic              rd_head_reg, rd_head_next;
    logic [BYTE_W-1:0] key_reg, key_next;
    logic [K_W-1:0]    k_reg, k_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_has_reg, out_has_next;
    logic              out_last_reg, out_last_next;
    logic              out_drop_reg, out_drop_next;

    logic [LINK_W-1:0] next_val;
    logic [LINK_W-1:0] n_eff;
    logic [LINK_W-1:0] rc_dec;
    logic              out_free;
    logic              dump_last;

    // Memory port controls.
    logic              link_rd_en;
    logic [LINK_W-1:0] link_rd_addr;
    logic              char_rd_en;
    logic              stack_rd_en;
    logic              next_we;
    logic [LINK_W-1:0] next_wa, next_wd;
    logic              prev_we;
    logic [LINK_W-1:0] prev_wa, prev_wd;
    logic              char_we;
    logic [LINK_W-1:0] char_wa;
    logic              stack_we;

    // A read of next_link at node zero returns the head register.
    assign next_val  = rd_head_reg ? head_reg : next_q_reg;
    assign n_eff     = use_stack_reg ? stack_q_reg : node_reg;
    assign rc_dec    = rc_reg - LINK_W'(1);
    assign out_free  = !out_valid_reg || m_tready;
    assign dump_last = (next_val == NULL_L) || (k_reg == K_LAST);

    assign status.cur_home   = (caret_reg == NULL_L);
    assign status.cur_tail   = (caret_reg == tail_reg);
    assign status.store_full = (rc_reg == NULL_L) && (fresh_reg > CAP_L);
    assign status.node_bad   = (n_eff == NULL_L) || (n_eff > CAP_L);
    assign status.head_empty = (head_reg == NULL_L);
    assign status.out_free   = out_free;
    assign status.dump_last  = dump_last;

    assign m_tvalid   = out_valid_reg;
    assign m_byte     = out_byte_reg;
    assign m_has_char = out_has_reg;
    assign m_last     = out_last_reg;
    assign m_dropped  = out_drop_reg;

    always_comb
    begin
        caret_next     = caret_reg;
        tail_next      = tail_reg;
        head_next      = head_reg;
        fresh_next     = fresh_reg;
        rc_next        = rc_reg;
        overflow_next  = overflow_reg;
        node_next      = node_reg;
        after_next     = after_reg;
        use_stack_next = use_stack_reg;
        rd_head_next   = rd_head_reg;
        key_next       = key_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_has_next   = out_has_reg;
        out_last_next  = out_last_reg;
        out_drop_next  = out_drop_reg;

        link_rd_en   = 1'b0;
        link_rd_addr = caret_reg;
        char_rd_en   = 1'b0;
        stack_rd_en  = 1'b0;
        next_we      = 1'b0;
        next_wa      = caret_reg;
        next_wd      = node_reg;
        prev_we      = 1'b0;
        prev_wa      = after_reg;
        prev_wd      = node_reg;
        char_we      = 1'b0;
        char_wa      = n_eff;
        stack_we     = 1'b0;

        if (cmd.accept)
        begin
            key_next = key_byte;
        end

        case (cmd.op)
            OP_CUR_HOME:
            begin
                caret_next = NULL_L;
            end
            OP_CUR_TAIL:
            begin
                caret_next = tail_reg;
            end
            OP_RD_PREV:
            begin
                link_rd_en = 1'b1;
            end
            OP_LD_PREV:
            begin
                caret_next = prev_q_reg;
            end
            OP_RD_NEXT:
            begin
                link_rd_en = 1'b1;
            end
            OP_LD_NEXT:
            begin
                caret_next = next_val;
            end
            OP_DEL_RD:
            begin
                link_rd_en = 1'b1;
            end
            OP_DEL_WR:
            begin
                // Unlink the cursor node and return it to the free stack.
                next_we     = 1'b1;
                next_wa     = prev_q_reg;
                next_wd     = next_val;
                if (next_val != NULL_L)
                begin
                    prev_we = 1'b1;
                    prev_wa = next_val;
                    prev_wd = prev_q_reg;
                end
                else
                begin
                    tail_next = prev_q_reg;
                end
                if (rc_reg < CAP_L)
                begin
                    stack_we = 1'b1;
                    rc_next  = rc_reg + LINK_W'(1);
                end
                caret_next = prev_q_reg;
            end
            OP_INS_TAKE:
            begin
                // Freed nodes go out before fresh ones.
                link_rd_en = 1'b1;
                if (rc_reg != NULL_L)
                begin
                    stack_rd_en    = 1'b1;
                    rc_next        = rc_dec;
                    use_stack_next = 1'b1;
                end
                else if (fresh_reg <= CAP_L)
                begin
                    node_next      = fresh_reg;
                    fresh_next     = fresh_reg + LINK_W'(1);
                    use_stack_next = 1'b0;
                end
                else
                begin
                    overflow_next = 1'b1;
                end
            end
            OP_INS_W1:
            begin
                if (status.node_bad)
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    char_we    = 1'b1;
                    prev_we    = 1'b1;
                    prev_wa    = n_eff;
                    prev_wd    = caret_reg;
                    next_we    = 1'b1;
                    next_wa    = n_eff;
                    next_wd    = next_val;
                    node_next  = n_eff;
                    after_next = next_val;
                end
            end
            OP_INS_W2:
            begin
                next_we = 1'b1;
                next_wa = caret_reg;
                next_wd = node_reg;
                if (after_reg != NULL_L)
                begin
                    prev_we = 1'b1;
                end
                else
                begin
                    tail_next = node_reg;
                end
                caret_next = node_reg;
            end
            OP_DUMP_EMPTY:
            begin
                out_valid_next = 1'b1;
                out_byte_next  = '0;
                out_has_next   = 1'b0;
                out_last_next  = 1'b1;
                out_drop_next  = overflow_reg;
            end
            OP_DUMP_FIRST:
            begin
                link_rd_en   = 1'b1;
                char_rd_en   = 1'b1;
                link_rd_addr = head_reg;
                k_next       = '0;
            end
            OP_DUMP_STEP:
            begin
                out_valid_next = 1'b1;
                out_byte_next  = char_q_reg;
                out_has_next   = 1'b1;
                out_last_next  = dump_last;
                out_drop_next  = overflow_reg;
                if (!dump_last)
                begin
                    link_rd_en   = 1'b1;
                    char_rd_en   = 1'b1;
                    link_rd_addr = next_val;
                    k_next       = k_reg + K_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        if (link_rd_en)
        begin
            rd_head_next = (link_rd_addr == NULL_L);
        end
        if (next_we && (next_wa == NULL_L))
        begin
            head_next = next_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            caret_reg     <= '0;
            tail_reg      <= '0;
            head_reg      <= '0;
            fresh_reg     <= LINK_W'(1);
            rc_reg        <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            caret_reg     <= caret_next;
            tail_reg      <= tail_next;
            head_reg      <= head_next;
            fresh_reg     <= fresh_next;
            rc_reg        <= rc_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers need no reset.
    always_ff @(posedge clk)
    begin
        node_reg      <= node_next;
        after_reg     <= after_next;
        use_stack_reg <= use_stack_next;
        rd_head_reg   <= rd_head_next;
        key_reg       <= key_next;
        k_reg         <= k_next;
        out_byte_reg  <= out_byte_next;
        out_has_reg   <= out_has_next;
        out_last_reg  <= out_last_next;
        out_drop_reg  <= out_drop_next;
    end

    // Memories: one write and one registered read each per cycle.
    always_ff @(posedge clk)
    begin
        if (next_we && (next_wa != NULL_L))
        begin
            next_mem[next_wa[IDX_W-1:0]] <= next_wd;
        end
        if (link_rd_en)
        begin
            next_q_reg <= next_mem[link_rd_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa[IDX_W-1:0]] <= prev_wd;
        end
        if (link_rd_en)
        begin
            prev_q_reg <= prev_mem[link_rd_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_we)
        begin
            char_mem[char_wa[IDX_W-1:0]] <= key_reg;
        end
        if (char_rd_en)
        begin
            char_q_reg <= char_mem[link_rd_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[rc_reg[SIDX_W-1:0]] <= caret_reg;
        end
        if (stack_rd_en)
        begin
            stack_q_reg <= stack_mem[rc_dec[SIDX_W-1:0]];
        end
    end

`ifndef NO_ASSERTIONS
    // The free stack never holds more nodes than were handed out, and no more than CAPACITY are handed out.
    a_node_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rc_reg < fresh_reg) && (fresh_reg <= CAP_L + LINK_W'(1)))
        else $error("free stack holds more nodes than were ever handed out");

    // Head and tail agree on whether the line is empty.
    a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NULL_L) == (tail_reg == NULL_L))
        else $error("head and tail disagree on an empty line");

    // The cursor and the tail always name the sentinel or a character node.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (caret_reg <= CAP_L) && (tail_reg <= CAP_L))
        else $error("cursor or tail outside the node range");

    // A word without a character is only ever the single word of an empty dump.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_has_reg) |-> out_last_reg)
        else $error("empty word not marked last");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/cursor_line_edit_buffer.sv -----
// Top level of the cursor line edit buffer: controller plus datapath.
// Depends on cleb_pkg, cleb_ctrl and cleb_datapath.
//
// Usage:
//   The input channel (s_*) takes one word per item. s_tuser selects the kind:
//   a keystroke (0) or a dump request (1). s_tdata carries the key byte.
//   Keystrokes edit the line and produce no output. A dump walks the line and
//   sends one output word per character on the m_* channel, with m_tlast on
//   the final one; an empty line gives a single word with has_char low.
//   The dropped flag is sticky and reports an insert lost to a full store.
// Sequencing:
//   Cursor home, end and newline are handled as accepted. Left and right read
//   the link memories, then load the cursor; backspace reads the links, then
//   writes them; an insert takes a node and reads the links, then writes the
//   node and its links. A dump reads the head node, then walks one node per
//   cycle while the output is free, the registered next-link read feeding the
//   address of the following read. The input is not ready while an item is being worked on.
// Reset:
//   rst_n clears the line to empty, the cursor to home and the dropped flag.
//   No clearing pass is needed; the block is ready right after reset.
// Stall:
//   A word waiting on the output register does not block keystrokes; a dump
//   walk holds in place while the receiver stalls.
`timescale 1ns / 1ps
`default_nettype none

module cursor_line_edit_buffer
    import cleb_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,   // [7:0] key_byte
    input  wire logic              s_tuser,   // [0] kind
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [BYTE_W-1:0]      m_tdata,   // [7:0] text_byte
    output logic                   m_tlast,   // last word of a dump
    output logic [1:0]             m_tuser    // [0] has_char, [1] dropped
);

    // Command and status between the state machine and the datapath.
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       has_char;
    logic       dropped;

    cleb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .key_byte (s_tdata),
        .kind     (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    cleb_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .key_byte   (s_tdata),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_byte     (m_tdata),
        .m_has_char (has_char),
        .m_last     (m_tlast),
        .m_dropped  (dropped)
    );

    // Flags travel together on tuser, has_char in the low bit.
    assign m_tuser = {dropped, has_char};

endmodule

`default_nettype wire
